>>> rtl/core/bpc_pkg.sv
// Shared constants and types of the barometric pressure compensation block.
package bpc_pkg;

   // Stream payload widths.
   localparam int REQ_W = 40;
   localparam int RSP_W = 96;

   // Result word layout.
   localparam int PRESS_LSB = 64;
   localparam int PRESS_MSB = 95;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Quotient bits, one per division step.
   localparam int DIV_STEPS = 64;

   // Calibration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_T1  = 3'd0,
      REG_T2  = 3'd1,
      REG_T3  = 3'd2,
      REG_P1  = 3'd3,
      REG_P23 = 3'd4,
      REG_P45 = 3'd5,
      REG_P67 = 3'd6,
      REG_P89 = 3'd7
   } csr_reg_type;

endpackage

>>> rtl/core/barometric_pressure_compensation.sv
// Top level of the pipelined barometric pressure compensation block.
//
// One raw temperature and raw pressure pair is taken per cycle unless stalled,
// each giving one result: 12 stages evaluate the temperature and pressure
// polynomials, 65 stages run the signed 64-bit division (magnitudes first,
// then one quotient bit per stage), 6 stages apply the final pressure terms
// and one output register holds the result. While the output stalls, the
// pipeline advances and takes new pairs until the last stage is occupied.
// The user must write calibration words through the csr port while no pair
// is in flight; the block does not enforce this. A zero divisor gives pressure
// 0 with pressure_valid low; the temperature fields are always given.
module barometric_pressure_compensation (
   input  logic                            clock,
   input  logic                            reset,
   // raw_temperature[19:0], raw_pressure[39:20]
   input  logic [bpc_pkg::REQ_W-1:0]       req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // temperature_centi[31:0], fine_temperature[63:32], pressure_q24_8[95:64]
   output logic [bpc_pkg::RSP_W-1:0]       rsp_tdata,
   // pressure_valid[0]
   output logic [0:0]                      rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Temperature results carried along the pipeline.
   typedef struct packed {
      logic signed [19:0] tcent;
      logic signed [24:0] tfine;
   } tmp_type;

   typedef struct packed {
      logic               vld;
      logic signed [17:0] a;
      logic signed [16:0] b;
      logic [20:0]        pn;
   } s1_type;

   typedef struct packed {
      logic               vld;
      logic signed [33:0] tp1;
      logic signed [33:0] bb;
      logic [20:0]        pn;
   } s2_type;

   typedef struct packed {
      logic               vld;
      logic signed [22:0] tv1;
      logic signed [37:0] tp2;
      logic [20:0]        pn;
   } s3_type;

   typedef struct packed {
      logic               vld;
      logic signed [24:0] tfine;
      logic [20:0]        pn;
   } s4_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic signed [25:0] pv1;
      logic [20:0]        pn;
   } s5_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic [20:0]        pn;
      logic signed [51:0] sq;
      logic signed [41:0] v1p5;
      logic signed [41:0] v1p2;
   } s6_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic [20:0]        pn;
      logic signed [42:0] lo6;
      logic signed [41:0] hi6;
      logic signed [42:0] lo3;
      logic signed [41:0] hi3;
      logic signed [41:0] v1p2;
      logic [63:0]        v2b;
   } s7_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic [20:0]        pn;
      logic [63:0]        sqp6;
      logic [63:0]        sqp3;
      logic [63:0]        c;
      logic [63:0]        v2b;
   } s8_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic [20:0]        pn;
      logic [63:0]        v2;
      logic [63:0]        y;
   } s9_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic [47:0]        ylo;
      logic [31:0]        yhi;
      logic [63:0]        numa;
   } s10_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic signed [30:0] d;
      logic [43:0]        nlo;
      logic [31:0]        nhi;
   } s11_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic signed [30:0] d;
      logic [63:0]        num;
   } s12_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic               neg;
      logic [30:0]        dm;
      logic [30:0]        rem;
      logic [63:0]        quo;
   } div_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        p;
   } q1_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        p;
      logic signed [48:0] l9;
      logic [31:0]        h9;
      logic signed [48:0] l8;
      logic [31:0]        h8;
   } q2_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        p;
      logic [63:0]        m1;
      logic [63:0]        pp8;
   } q3_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        mf;
      logic [31:0]        c1;
      logic [31:0]        c2;
      logic [63:0]        pv2;
   } q4_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        m2;
      logic [63:0]        pv2;
   } q5_type;

   typedef struct packed {
      logic               vld;
      tmp_type            tmp;
      logic               nz;
      logic [63:0]        s;
   } q6_type;

   // One restoring division step: shift in a dividend bit, try to subtract.
   function automatic div_type div_step(input div_type x);
      div_type     r;
      logic [31:0] t;
      logic [32:0] diff;
      r    = x;
      t    = {x.rem, x.quo[63]};
      diff = {1'b0, t} - {2'b00, x.dm};
      if (!diff[32]) begin
         r.rem = diff[30:0];
         r.quo = {x.quo[62:0], 1'b1};
      end else begin
         r.rem = t[30:0];
         r.quo = {x.quo[62:0], 1'b0};
      end
      return r;
   endfunction

   // Calibration registers.
   logic [15:0] cal_t1_ff, cal_t2_ff, cal_t3_ff, cal_p1_ff;
   logic [31:0] cal_p23_ff, cal_p45_ff, cal_p67_ff, cal_p89_ff;

   logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

   assign w_t2 = signed'(cal_t2_ff);
   assign w_t3 = signed'(cal_t3_ff);
   assign w_p2 = signed'(cal_p23_ff[15:0]);
   assign w_p3 = signed'(cal_p23_ff[31:16]);
   assign w_p4 = signed'(cal_p45_ff[15:0]);
   assign w_p5 = signed'(cal_p45_ff[31:16]);
   assign w_p6 = signed'(cal_p67_ff[15:0]);
   assign w_p7 = signed'(cal_p67_ff[31:16]);
   assign w_p8 = signed'(cal_p89_ff[15:0]);
   assign w_p9 = signed'(cal_p89_ff[31:16]);

   // Register writes from the csr port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff  <= '0;
         cal_t2_ff  <= '0;
         cal_t3_ff  <= '0;
         cal_p1_ff  <= '0;
         cal_p23_ff <= '0;
         cal_p45_ff <= '0;
         cal_p67_ff <= '0;
         cal_p89_ff <= '0;
      end else if (csr_wr_en) begin
         case (bpc_pkg::csr_reg_type'(csr_index))
            bpc_pkg::REG_T1:  cal_t1_ff  <= csr_wdata[15:0];
            bpc_pkg::REG_T2:  cal_t2_ff  <= csr_wdata[15:0];
            bpc_pkg::REG_T3:  cal_t3_ff  <= csr_wdata[15:0];
            bpc_pkg::REG_P1:  cal_p1_ff  <= csr_wdata[15:0];
            bpc_pkg::REG_P23: cal_p23_ff <= csr_wdata;
            bpc_pkg::REG_P45: cal_p45_ff <= csr_wdata;
            bpc_pkg::REG_P67: cal_p67_ff <= csr_wdata;
            bpc_pkg::REG_P89: cal_p89_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline registers.
   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s5_type  s5_ff,  s5_in;
   s6_type  s6_ff,  s6_in;
   s7_type  s7_ff,  s7_in;
   s8_type  s8_ff,  s8_in;
   s9_type  s9_ff,  s9_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;
   s12_type s12_ff, s12_in;
   div_type div_ff [0:bpc_pkg::DIV_STEPS];
   div_type div_in [0:bpc_pkg::DIV_STEPS];
   q1_type  q1_ff,  q1_in;
   q2_type  q2_ff,  q2_in;
   q3_type  q3_ff,  q3_in;
   q4_type  q4_ff,  q4_in;
   q5_type  q5_ff,  q5_in;
   q6_type  q6_ff,  q6_in;

   logic               rsp_vld_ff;
   logic [bpc_pkg::RSP_W-1:0] rsp_data_ff;
   logic               rsp_user_ff;

   logic               ce;
   logic               out_load;
   logic [19:0]        raw_t;
   logic [19:0]        raw_p;
   logic signed [27:0] tc5;
   logic [63:0]        ysum;
   logic [63:0]        ps2;
   logic [63:0]        ps4;
   logic [31:0]        press_w;

   // The pipeline moves unless a finished item in the last stage is blocked.
   assign out_load   = !rsp_vld_ff || rsp_tready;
   assign ce         = !(q6_ff.vld && !out_load);
   assign req_tready = ce;

   assign raw_t = req_tdata[19:0];
   assign raw_p = req_tdata[39:20];

   assign tc5  = (28'(s4_ff.tfine) <<< 2) + 28'(s4_ff.tfine) + 28'sd128;
   assign ysum = 64'(s10_ff.ylo) + {s10_ff.yhi, 32'd0};
   assign ps2  = 64'(signed'(q1_ff.p) >>> 13);
   assign ps4  = 64'(signed'(q3_ff.p) >>> 13);

   // Temperature polynomial and the pressure terms ahead of the division.
   always_comb begin
      s1_in.vld = req_tvalid;
      s1_in.a   = signed'(18'({1'b0, raw_t[19:3]}) - 18'({cal_t1_ff, 1'b0}));
      s1_in.b   = signed'({1'b0, raw_t[19:4]} - {1'b0, cal_t1_ff});
      s1_in.pn  = 21'h100000 - {1'b0, raw_p};

      s2_in.vld = s1_ff.vld;
      s2_in.tp1 = 34'(s1_ff.a) * 34'(w_t2);
      s2_in.bb  = 34'(s1_ff.b) * 34'(s1_ff.b);
      s2_in.pn  = s1_ff.pn;

      s3_in.vld = s2_ff.vld;
      s3_in.tv1 = 23'(s2_ff.tp1 >>> 11);
      s3_in.tp2 = 38'(s2_ff.bb >>> 12) * 38'(w_t3);
      s3_in.pn  = s2_ff.pn;

      s4_in.vld   = s3_ff.vld;
      s4_in.tfine = 25'(s3_ff.tv1) + 25'(s3_ff.tp2 >>> 14);
      s4_in.pn    = s3_ff.pn;

      s5_in.vld       = s4_ff.vld;
      s5_in.tmp.tfine = s4_ff.tfine;
      s5_in.tmp.tcent = 20'(tc5 >>> 8);
      s5_in.pv1       = 26'(s4_ff.tfine) - 26'sd128000;
      s5_in.pn        = s4_ff.pn;

      // Squared and linear fine temperature terms.
      s6_in.vld  = s5_ff.vld;
      s6_in.tmp  = s5_ff.tmp;
      s6_in.pn   = s5_ff.pn;
      s6_in.sq   = 52'(s5_ff.pv1) * 52'(s5_ff.pv1);
      s6_in.v1p5 = 42'(s5_ff.pv1) * 42'(w_p5);
      s6_in.v1p2 = 42'(s5_ff.pv1) * 42'(w_p2);

      // Square times word six and word three, split into two halves each.
      s7_in.vld  = s6_ff.vld;
      s7_in.tmp  = s6_ff.tmp;
      s7_in.pn   = s6_ff.pn;
      s7_in.lo6  = 43'(signed'({1'b0, s6_ff.sq[25:0]})) * 43'(w_p6);
      s7_in.hi6  = 42'(signed'({1'b0, s6_ff.sq[50:26]})) * 42'(w_p6);
      s7_in.lo3  = 43'(signed'({1'b0, s6_ff.sq[25:0]})) * 43'(w_p3);
      s7_in.hi3  = 42'(signed'({1'b0, s6_ff.sq[50:26]})) * 42'(w_p3);
      s7_in.v1p2 = s6_ff.v1p2;
      s7_in.v2b  = (64'(s6_ff.v1p5) << 17) + (64'(w_p4) << 35);

      s8_in.vld  = s7_ff.vld;
      s8_in.tmp  = s7_ff.tmp;
      s8_in.pn   = s7_ff.pn;
      s8_in.sqp6 = 64'(s7_ff.lo6) + (64'(s7_ff.hi6) << 26);
      s8_in.sqp3 = 64'(s7_ff.lo3) + (64'(s7_ff.hi3) << 26);
      s8_in.c    = (64'(s7_ff.v1p2) << 12) + 64'h0000_8000_0000_0000;
      s8_in.v2b  = s7_ff.v2b;

      s9_in.vld = s8_ff.vld;
      s9_in.tmp = s8_ff.tmp;
      s9_in.pn  = s8_ff.pn;
      s9_in.v2  = s8_ff.sqp6 + s8_ff.v2b;
      s9_in.y   = 64'(signed'(s8_ff.sqp3) >>> 8) + s8_ff.c;

      // Divisor scaling by word one and the dividend before scaling.
      s10_in.vld  = s9_ff.vld;
      s10_in.tmp  = s9_ff.tmp;
      s10_in.ylo  = 48'(s9_ff.y[31:0]) * 48'(cal_p1_ff);
      s10_in.yhi  = 32'(s9_ff.y[63:32] * 32'(cal_p1_ff));
      s10_in.numa = 64'({s9_ff.pn, 31'd0}) - s9_ff.v2;

      s11_in.vld = s10_ff.vld;
      s11_in.tmp = s10_ff.tmp;
      s11_in.d   = signed'(ysum[63:33]);
      s11_in.nlo = 44'(s10_ff.numa[31:0]) * 44'd3125;
      s11_in.nhi = 32'(s10_ff.numa[63:32] * 32'd3125);

      s12_in.vld = s11_ff.vld;
      s12_in.tmp = s11_ff.tmp;
      s12_in.d   = s11_ff.d;
      s12_in.num = 64'(s11_ff.nlo) + {s11_ff.nhi, 32'd0};
   end

   // Division: magnitudes first, then one quotient bit per stage.
   always_comb begin
      div_in[0].vld = s12_ff.vld;
      div_in[0].tmp = s12_ff.tmp;
      div_in[0].nz  = (s12_ff.d != 31'sd0);
      div_in[0].neg = s12_ff.num[63] ^ s12_ff.d[30];
      div_in[0].dm  = s12_ff.d[30] ? (31'd0 - unsigned'(s12_ff.d)) : unsigned'(s12_ff.d);
      div_in[0].rem = '0;
      div_in[0].quo = s12_ff.num[63] ? (64'd0 - s12_ff.num) : s12_ff.num;
      for (int k = 1; k <= bpc_pkg::DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   // Final pressure terms after the division.
   always_comb begin
      q1_in.vld = div_ff[bpc_pkg::DIV_STEPS].vld;
      q1_in.tmp = div_ff[bpc_pkg::DIV_STEPS].tmp;
      q1_in.nz  = div_ff[bpc_pkg::DIV_STEPS].nz;
      q1_in.p   = div_ff[bpc_pkg::DIV_STEPS].neg ?
                  (64'd0 - div_ff[bpc_pkg::DIV_STEPS].quo) : div_ff[bpc_pkg::DIV_STEPS].quo;

      q2_in.vld = q1_ff.vld;
      q2_in.tmp = q1_ff.tmp;
      q2_in.nz  = q1_ff.nz;
      q2_in.p   = q1_ff.p;
      q2_in.l9  = 49'(signed'({1'b0, ps2[31:0]})) * 49'(w_p9);
      q2_in.h9  = 32'(ps2[63:32] * 32'(w_p9));
      q2_in.l8  = 49'(signed'({1'b0, q1_ff.p[31:0]})) * 49'(w_p8);
      q2_in.h8  = 32'(q1_ff.p[63:32] * 32'(w_p8));

      q3_in.vld = q2_ff.vld;
      q3_in.tmp = q2_ff.tmp;
      q3_in.nz  = q2_ff.nz;
      q3_in.p   = q2_ff.p;
      q3_in.m1  = 64'(q2_ff.l9) + {q2_ff.h9, 32'd0};
      q3_in.pp8 = 64'(q2_ff.l8) + {q2_ff.h8, 32'd0};

      q4_in.vld = q3_ff.vld;
      q4_in.tmp = q3_ff.tmp;
      q4_in.nz  = q3_ff.nz;
      q4_in.mf  = 64'(q3_ff.m1[31:0]) * 64'(ps4[31:0]);
      q4_in.c1  = 32'(q3_ff.m1[31:0] * ps4[63:32]);
      q4_in.c2  = 32'(q3_ff.m1[63:32] * ps4[31:0]);
      q4_in.pv2 = q3_ff.p + 64'(signed'(q3_ff.pp8) >>> 19);

      q5_in.vld = q4_ff.vld;
      q5_in.tmp = q4_ff.tmp;
      q5_in.nz  = q4_ff.nz;
      q5_in.m2  = q4_ff.mf + {q4_ff.c1 + q4_ff.c2, 32'd0};
      q5_in.pv2 = q4_ff.pv2;

      q6_in.vld = q5_ff.vld;
      q6_in.tmp = q5_ff.tmp;
      q6_in.nz  = q5_ff.nz;
      q6_in.s   = q5_ff.pv2 + 64'(signed'(q5_ff.m2) >>> 25);
   end

   // Pressure with the word seven offset; zero when the divisor was zero.
   assign press_w = q6_ff.nz ? (q6_ff.s[39:8] + (32'(w_p7) << 4)) : 32'd0;

   // Stage registers, all advancing together.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld  <= 1'b0;
         s2_ff.vld  <= 1'b0;
         s3_ff.vld  <= 1'b0;
         s4_ff.vld  <= 1'b0;
         s5_ff.vld  <= 1'b0;
         s6_ff.vld  <= 1'b0;
         s7_ff.vld  <= 1'b0;
         s8_ff.vld  <= 1'b0;
         s9_ff.vld  <= 1'b0;
         s10_ff.vld <= 1'b0;
         s11_ff.vld <= 1'b0;
         s12_ff.vld <= 1'b0;
         for (int k = 0; k <= bpc_pkg::DIV_STEPS; k++) begin
            div_ff[k].vld <= 1'b0;
         end
         q1_ff.vld <= 1'b0;
         q2_ff.vld <= 1'b0;
         q3_ff.vld <= 1'b0;
         q4_ff.vld <= 1'b0;
         q5_ff.vld <= 1'b0;
         q6_ff.vld <= 1'b0;
      end else if (ce) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         s12_ff <= s12_in;
         for (int k = 0; k <= bpc_pkg::DIV_STEPS; k++) begin
            div_ff[k] <= div_in[k];
         end
         q1_ff <= q1_in;
         q2_ff <= q2_in;
         q3_ff <= q3_in;
         q4_ff <= q4_in;
         q5_ff <= q5_in;
         q6_ff <= q6_in;
      end
   end

   // Output register: loads whenever it is empty or its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= q6_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {press_w, 32'(q6_ff.tmp.tfine), 32'(q6_ff.tmp.tcent)};
         rsp_user_ff <= q6_ff.nz;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

>>> rtl/core/bpc_checker.sv
// Port-level checks of the barometric pressure compensation block, with its bind.
module bpc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [bpc_pkg::RSP_W-1:0] rsp_tdata,
   input logic [0:0]                rsp_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready
);

   // A result that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before its transfer");

   // A result that is held back keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // Without a usable divisor the pressure field reads zero.
   a_press_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
      rsp_tdata[bpc_pkg::PRESS_MSB:bpc_pkg::PRESS_LSB] == 32'd0)
      else $error("nonzero pressure with pressure_valid low");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // With the output empty the block always takes a new pair.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the output is empty");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
